/* design/arm_subset_execute_defines.svh */
// Assertion macros for the ARM subset execute block.
// Included by the top level; depends on nothing else.
`ifndef ARM_SUBSET_EXECUTE_DEFINES_SVH
`define ARM_SUBSET_EXECUTE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ASE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ase assertion failed");

// Next-cycle implication, held off during reset.
`define ASE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ase assertion failed");

`endif

/* design/ase_pkg.sv */
// Package of the ARM subset execute block: payload structs, codes, constants.
// Used by arm_subset_execute; depends on nothing.
`timescale 1ns / 1ps

package ase_pkg;

   localparam int unsigned DMEM_WORDS_DEFAULT = 1024;
   localparam int unsigned NUM_REGS = 16;
   localparam int unsigned NUM_CFG = 6;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_LR = 4'd14;
   localparam logic [3:0] REG_PC = 4'd15;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_PRELOAD = 2'd1,
      ACT_EXECUTE = 2'd2,
      ACT_STATUS  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CLS_NONE   = 3'd0,
      CLS_BX     = 3'd1,
      CLS_MUL    = 3'd2,
      CLS_DP     = 3'd3,
      CLS_MEM    = 3'd4,
      CLS_BRANCH = 3'd5
   } class_type;

   typedef enum logic [2:0] {
      CNT_IC  = 3'd0,
      CNT_DP  = 3'd1,
      CNT_MEM = 3'd2,
      CNT_BR  = 3'd3,
      CNT_BT  = 3'd4,
      CNT_BNT = 3'd5
   } counter_type;

   typedef enum logic [2:0] {
      CFG_START = 3'd0,
      CFG_STACK = 3'd1,
      CFG_ARG0  = 3'd2,
      CFG_ARG1  = 3'd3,
      CFG_ARG2  = 3'd4,
      CFG_ARG3  = 3'd5
   } cfg_index_type;

   localparam logic [3:0] OP_ADD = 4'b0100;
   localparam logic [3:0] OP_SUB = 4'b0010;
   localparam logic [3:0] OP_MOV = 4'b1101;
   localparam logic [3:0] OP_CMP = 4'b1010;

   localparam logic [3:0] COND_EQ = 4'h0;
   localparam logic [3:0] COND_NE = 4'h1;
   localparam logic [3:0] COND_GE = 4'hA;
   localparam logic [3:0] COND_AL = 4'hE;

   localparam logic [31:0] BX_MASK    = 32'h0FFF_FFF0;
   localparam logic [31:0] BX_PATTERN = 32'h012F_FF10;
   localparam logic [31:0] MUL_MASK    = 32'h0FC0_00F0;
   localparam logic [31:0] MUL_PATTERN = 32'h0000_0090;

   localparam logic [31:0] STACK_RESET = 32'd4096;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] instr_word;
      logic [9:0]  preload_index;
      logic [31:0] preload_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] result_value;
      logic        halted;
      logic [2:0]  instr_class;
      logic        branch_taken;
      logic [31:0] instr_count;
      logic [31:0] compute_count;
      logic [31:0] memory_count;
      logic [31:0] branch_count;
      logic [31:0] taken_count;
      logic [31:0] not_taken_count;
   } rsp_type;

endpackage

/* design/arm_subset_execute.sv */
// Top level of the ARM subset execute block: decode, register file, flags,
// counters, data memory and configuration registers. Depends on ase_pkg.
`timescale 1ns / 1ps
`include "arm_subset_execute_defines.svh"

// Usage: items arrive on the req_ channel (valid/ready); each one gives exactly one
// result on the rsp_ channel. Start, preload, status and all non-load instructions
// are done at the accepting edge: the result is registered there and the next
// transfer can be accepted in the following cycle. A load (ldr, ldrb) reads the
// registered port of the data memory into rdata_ff; while it is pending the block
// holds req_ready low, then writes the loaded word back and registers the result.
// The result register holds one item; while the receiver stalls it keeps its
// transfer and req_ready stays low until rsp_ready returns.
// Reset clears registers, flags, counters and the configuration registers (stack
// top returns to 4096). Data memory is not cleared. The configuration port is
// written with psel, penable and pwrite high; pready is tied high.
// DMEM_WORDS must be a power of two; addresses wrap on the word index.
module arm_subset_execute #(
   parameter int unsigned DMEM_WORDS = ase_pkg::DMEM_WORDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ase_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ase_pkg::rsp_type                  rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ase_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ase_pkg::*;

   localparam int unsigned AW = $clog2(DMEM_WORDS);

   logic [31:0] cfg_ff [NUM_CFG];
   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] regs_in [NUM_REGS];
   logic [3:0]  flags_ff, flags_in;
   logic [31:0] cnt_ff [6];
   logic [31:0] cnt_in [6];
   logic [31:0] dmem [DMEM_WORDS];
   logic [31:0] rdata_ff;

   logic        ld_pend_ff;
   logic [3:0]  ld_rd_ff;
   logic        ld_byte_ff;
   logic [1:0]  ld_lane_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept, is_load, cfg_we;
   logic        mem_re, mem_we;
   logic [AW-1:0] mem_idx;
   logic [3:0]  mem_be;
   logic [31:0] mem_wdata;
   logic [1:0]  addr_lane;
   logic [2:0]  cls;
   logic        taken;

   assign pready   = 1'b1;
   assign cfg_we   = psel && penable && pwrite;
   assign req_ready = !ld_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      prdata = '0;
      if (paddr[4:2] < 3'(NUM_CFG)) begin
         prdata = cfg_ff[paddr[4:2]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= '0;
         end
         cfg_ff[CFG_STACK] <= STACK_RESET;
      end else if (cfg_we && paddr[4:2] < 3'(NUM_CFG)) begin
         cfg_ff[paddr[4:2]] <= pwdata;
      end
   end

   always_comb begin
      logic [31:0] iw, pc, a, op2, off, addr, res, w;
      logic [3:0]  rd, rn, op, cond;
      logic        sa_gt0, sa_lt0, sb_gt0, sb_lt0, rneg, rpos, ok;
      iw = req_payload.instr_word;
      pc = regs_ff[REG_PC];
      rd = iw[15:12];
      rn = iw[19:16];
      op = iw[24:21];
      cond = iw[31:28];
      a = regs_ff[rn];
      op2 = iw[25] ? {24'd0, iw[7:0]} : regs_ff[iw[3:0]];
      off = iw[25] ? regs_ff[iw[3:0]] : {24'd0, iw[7:0]};
      addr = iw[23] ? a + off : a - off;
      addr_lane = addr[1:0];
      res = a - op2;
      rneg = res[31];
      rpos = !res[31] && (res != '0);
      sa_gt0 = !a[31] && (a != '0);
      sa_lt0 = a[31];
      sb_gt0 = !op2[31] && (op2 != '0);
      sb_lt0 = op2[31];
      ok = 1'b0;
      w = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      flags_in = flags_ff;
      cls = CLS_NONE;
      taken = 1'b0;
      is_load = 1'b0;
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_idx = addr[2 +: AW];
      mem_be = 4'b0000;
      mem_wdata = regs_ff[rd];
      if (ld_pend_ff) begin
         w = ld_byte_ff ? {24'd0, rdata_ff[8*ld_lane_ff +: 8]} : rdata_ff;
         regs_in[ld_rd_ff] = w;
         if (ld_rd_ff != REG_PC) begin
            regs_in[REG_PC] = pc + 32'd4;
         end
      end else if (accept) begin
         unique case (action_type'(req_payload.action))
            ACT_START: begin
               for (int i = 0; i < NUM_REGS; i++) begin
                  regs_in[i] = '0;
               end
               for (int i = 0; i < 6; i++) begin
                  cnt_in[i] = '0;
               end
               flags_in = '0;
               regs_in[REG_PC] = cfg_ff[CFG_START];
               regs_in[REG_SP] = cfg_ff[CFG_STACK];
               regs_in[0] = cfg_ff[CFG_ARG0];
               regs_in[1] = cfg_ff[CFG_ARG1];
               regs_in[2] = cfg_ff[CFG_ARG2];
               regs_in[3] = cfg_ff[CFG_ARG3];
            end
            ACT_PRELOAD: begin
               mem_we = 1'b1;
               mem_be = 4'b1111;
               mem_idx = AW'({{(AW > 10 ? AW - 10 : 1){1'b0}}, req_payload.preload_index});
               mem_wdata = req_payload.preload_data;
            end
            ACT_EXECUTE: begin
               if (pc != '0) begin
                  cnt_in[CNT_IC] = cnt_ff[CNT_IC] + 32'd1;
                  if ((iw & BX_MASK) == BX_PATTERN) begin
                     cls = CLS_BX;
                     taken = 1'b1;
                     regs_in[REG_PC] = regs_ff[iw[3:0]];
                     cnt_in[CNT_BR] = cnt_ff[CNT_BR] + 32'd1;
                     cnt_in[CNT_BT] = cnt_ff[CNT_BT] + 32'd1;
                  end else if ((iw & MUL_MASK) == MUL_PATTERN) begin
                     cls = CLS_MUL;
                     regs_in[rn] = regs_ff[iw[3:0]] * regs_ff[iw[11:8]];
                     if (rn != REG_PC) begin
                        regs_in[REG_PC] = pc + 32'd4;
                     end
                     cnt_in[CNT_DP] = cnt_ff[CNT_DP] + 32'd1;
                  end else if (iw[27:26] == 2'b00) begin
                     cls = CLS_DP;
                     cnt_in[CNT_DP] = cnt_ff[CNT_DP] + 32'd1;
                     if (op == OP_ADD || op == OP_SUB || op == OP_MOV) begin
                        regs_in[rd] = (op == OP_ADD) ? a + op2 :
                                      (op == OP_SUB) ? res : op2;
                     end else if (op == OP_CMP) begin
                        flags_in = {rneg, res == '0, $signed(op2) > $signed(a),
                                    (sa_gt0 && sb_lt0 && rneg) ||
                                    (sa_lt0 && sb_gt0 && rpos)};
                     end
                     if (rd != REG_PC) begin
                        regs_in[REG_PC] = pc + 32'd4;
                     end
                  end else if (iw[27:26] == 2'b01) begin
                     cls = CLS_MEM;
                     cnt_in[CNT_MEM] = cnt_ff[CNT_MEM] + 32'd1;
                     if (iw[20]) begin
                        is_load = 1'b1;
                        mem_re = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        if (iw[22]) begin
                           mem_be = 4'b0001 << addr[1:0];
                           mem_wdata = {4{regs_ff[rd][7:0]}};
                        end else begin
                           mem_be = 4'b1111;
                        end
                        if (rd != REG_PC) begin
                           regs_in[REG_PC] = pc + 32'd4;
                        end
                     end
                  end else if (iw[27:25] == 3'b101) begin
                     cls = CLS_BRANCH;
                     cnt_in[CNT_BR] = cnt_ff[CNT_BR] + 32'd1;
                     priority case (cond)
                        COND_AL: ok = 1'b1;
                        COND_EQ: ok = flags_ff[2];
                        COND_NE: ok = !flags_ff[2];
                        COND_GE: ok = flags_ff[3] == flags_ff[0];
                        default: ok = 1'b0;
                     endcase
                     if (ok) begin
                        taken = 1'b1;
                        if (iw[24]) begin
                           regs_in[REG_LR] = pc + 32'd4;
                        end
                        regs_in[REG_PC] = pc + {{6{iw[23]}}, iw[23:0], 2'b00} + 32'd8;
                        cnt_in[CNT_BT] = cnt_ff[CNT_BT] + 32'd1;
                     end else begin
                        regs_in[REG_PC] = pc + 32'd4;
                        cnt_in[CNT_BNT] = cnt_ff[CNT_BNT] + 32'd1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.next_pc = regs_in[REG_PC];
      rsp_in.result_value = regs_in[0];
      rsp_in.halted = regs_in[REG_PC] == '0;
      rsp_in.instr_class = ld_pend_ff ? CLS_MEM : cls;
      rsp_in.branch_taken = ld_pend_ff ? 1'b0 : taken;
      rsp_in.instr_count = cnt_in[CNT_IC];
      rsp_in.compute_count = cnt_in[CNT_DP];
      rsp_in.memory_count = cnt_in[CNT_MEM];
      rsp_in.branch_count = cnt_in[CNT_BR];
      rsp_in.taken_count = cnt_in[CNT_BT];
      rsp_in.not_taken_count = cnt_in[CNT_BNT];
      rsp_valid_in = ld_pend_ff || (accept && !is_load) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            cnt_ff[i] <= '0;
         end
         flags_ff <= '0;
         ld_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff <= regs_in;
         cnt_ff <= cnt_in;
         flags_ff <= flags_in;
         ld_pend_ff <= accept && is_load;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_pend_ff || (accept && !is_load)) begin
         rsp_ff <= rsp_in;
      end
      if (accept && is_load) begin
         ld_rd_ff <= req_payload.instr_word[15:12];
         ld_byte_ff <= req_payload.instr_word[22];
         ld_lane_ff <= addr_lane;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= dmem[mem_idx];
      end
      if (mem_we) begin
         for (int b = 0; b < 4; b++) begin
            if (mem_be[b]) begin
               dmem[mem_idx][8*b +: 8] <= mem_wdata[8*b +: 8];
            end
         end
      end
   end

   `ASE_ASSERT_NOW(a_load_blocks_input, clock, reset, ld_pend_ff, !req_ready)
   `ASE_ASSERT_NEXT(a_load_completes, clock, reset, accept && is_load, ld_pend_ff && !rsp_valid_ff)
   `ASE_ASSERT_NEXT(a_result_follows, clock, reset, (accept && !is_load) || ld_pend_ff, rsp_valid_ff)

endmodule

/* dv/arm_subset_execute_tb.sv */
// Self-checking testbench for arm_subset_execute: predicts every result of the
// instruction interpreter and compares it against the rsp_ channel transfers.
// Depends on ase_pkg and the arm_subset_execute RTL.
`timescale 1ns / 1ps

module arm_subset_execute_tb;
   import ase_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   arm_subset_execute DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   logic [31:0] cpu_regs[16];
   logic [3:0]  cpu_flags;
   logic [31:0] dmem[1024];
   bit          dmem_written[1024];
   logic [31:0] mix_count[6];
   logic [31:0] cfg_regs[6];
   rsp_type     expected_rsp[$];
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   bit          failed = 1'b0;

   function automatic void write_reg(logic [3:0] rd, logic [31:0] value);
      cpu_regs[rd] = value;
      if (rd != REG_PC) cpu_regs[REG_PC] = cpu_regs[REG_PC] + 32'd4;
   endfunction

   function automatic logic [31:0] transfer_address(logic [31:0] iw);
      logic [31:0] offset;
      offset = iw[25] ? cpu_regs[iw[3:0]] : {24'd0, iw[7:0]};
      return iw[23] ? cpu_regs[iw[19:16]] + offset : cpu_regs[iw[19:16]] - offset;
   endfunction

   function automatic bit is_transfer(logic [31:0] iw);
      return ((iw & BX_MASK) != BX_PATTERN) && ((iw & MUL_MASK) != MUL_PATTERN)
         && iw[27:26] == 2'b01;
   endfunction

   function automatic void compare_flags(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      r = a - b;
      cpu_flags[3] = r[31];
      cpu_flags[2] = (r == 0);
      cpu_flags[1] = $signed(b) > $signed(a);
      cpu_flags[0] = ($signed(a) > 0 && $signed(b) < 0 && r[31])
         || ($signed(a) < 0 && $signed(b) > 0 && !r[31] && r != 0);
   endfunction

   function automatic bit condition_met(logic [3:0] cond);
      case (cond)
         COND_AL: return 1'b1;
         COND_EQ: return cpu_flags[2];
         COND_NE: return !cpu_flags[2];
         COND_GE: return cpu_flags[3] == cpu_flags[0];
         default: return 1'b0;
      endcase
   endfunction

   function automatic rsp_type execute_item(req_type item);
      rsp_type res;
      logic [31:0] iw, op2, a, addr, w;
      logic [9:0] idx;
      logic [4:0] sh;
      class_type cls;
      bit taken;
      iw = item.instr_word;
      cls = CLS_NONE;
      taken = 1'b0;
      if (item.action == ACT_START) begin
         foreach (cpu_regs[i]) cpu_regs[i] = '0;
         foreach (mix_count[i]) mix_count[i] = '0;
         cpu_flags = '0;
         cpu_regs[REG_PC] = cfg_regs[CFG_START];
         cpu_regs[REG_SP] = cfg_regs[CFG_STACK];
         for (int i = 0; i < 4; i++) cpu_regs[i] = cfg_regs[CFG_ARG0 + i];
      end else if (item.action == ACT_PRELOAD) begin
         dmem[item.preload_index] = item.preload_data;
         dmem_written[item.preload_index] = 1'b1;
      end else if (item.action == ACT_EXECUTE && cpu_regs[REG_PC] != 0) begin
         mix_count[CNT_IC]++;
         if ((iw & BX_MASK) == BX_PATTERN) begin
            cls = CLS_BX;
            cpu_regs[REG_PC] = cpu_regs[iw[3:0]];
            mix_count[CNT_BR]++;
            mix_count[CNT_BT]++;
            taken = 1'b1;
         end else if ((iw & MUL_MASK) == MUL_PATTERN) begin
            cls = CLS_MUL;
            write_reg(iw[19:16], cpu_regs[iw[3:0]] * cpu_regs[iw[11:8]]);
            mix_count[CNT_DP]++;
         end else if (iw[27:26] == 2'b00) begin
            cls = CLS_DP;
            op2 = iw[25] ? {24'd0, iw[7:0]} : cpu_regs[iw[3:0]];
            a = cpu_regs[iw[19:16]];
            case (iw[24:21])
               OP_ADD: write_reg(iw[15:12], a + op2);
               OP_SUB: write_reg(iw[15:12], a - op2);
               OP_MOV: write_reg(iw[15:12], op2);
               default: begin
                  if (iw[24:21] == OP_CMP) compare_flags(a, op2);
                  if (iw[15:12] != REG_PC) cpu_regs[REG_PC] += 32'd4;
               end
            endcase
            mix_count[CNT_DP]++;
         end else if (iw[27:26] == 2'b01) begin
            cls = CLS_MEM;
            addr = transfer_address(iw);
            idx = addr[11:2];
            sh = {addr[1:0], 3'b000};
            if (iw[20]) begin
               w = dmem[idx];
               write_reg(iw[15:12], iw[22] ? ((w >> sh) & 32'hFF) : w);
            end else begin
               if (iw[22])
                  dmem[idx] = (dmem[idx] & ~(32'hFF << sh))
                     | ((cpu_regs[iw[15:12]] & 32'hFF) << sh);
               else
                  dmem[idx] = cpu_regs[iw[15:12]];
               dmem_written[idx] = 1'b1;
               if (iw[15:12] != REG_PC) cpu_regs[REG_PC] += 32'd4;
            end
            mix_count[CNT_MEM]++;
         end else if (iw[27:25] == 3'b101) begin
            cls = CLS_BRANCH;
            if (condition_met(iw[31:28])) begin
               if (iw[24]) cpu_regs[REG_LR] = cpu_regs[REG_PC] + 32'd4;
               cpu_regs[REG_PC] += {{6{iw[23]}}, iw[23:0], 2'b00} + 32'd8;
               mix_count[CNT_BT]++;
               taken = 1'b1;
            end else begin
               cpu_regs[REG_PC] += 32'd4;
               mix_count[CNT_BNT]++;
            end
            mix_count[CNT_BR]++;
         end
      end
      res.next_pc = cpu_regs[REG_PC];
      res.result_value = cpu_regs[0];
      res.halted = (cpu_regs[REG_PC] == 0);
      res.instr_class = cls;
      res.branch_taken = taken;
      res.instr_count = mix_count[CNT_IC];
      res.compute_count = mix_count[CNT_DP];
      res.memory_count = mix_count[CNT_MEM];
      res.branch_count = mix_count[CNT_BR];
      res.taken_count = mix_count[CNT_BT];
      res.not_taken_count = mix_count[CNT_BNT];
      return res;
   endfunction

   task automatic send_item(req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      expected_rsp.push_back(execute_item(item));
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_action(action_type act);
      req_type item;
      item = '0;
      item.action = act;
      item.instr_word = $urandom();
      item.preload_index = 10'($urandom());
      item.preload_data = $urandom();
      send_item(item);
   endtask

   task automatic send_preload(logic [9:0] index, logic [31:0] data);
      req_type item;
      item = '0;
      item.action = ACT_PRELOAD;
      item.preload_index = index;
      item.preload_data = data;
      send_item(item);
   endtask

   // A load or a byte store must never touch a word that was never written.
   task automatic send_instr(logic [31:0] iw);
      req_type item;
      logic [31:0] addr;
      if (cpu_regs[REG_PC] != 0 && is_transfer(iw)) begin
         addr = transfer_address(iw);
         if (!dmem_written[addr[11:2]]) send_preload(addr[11:2], $urandom());
      end
      item = '0;
      item.action = ACT_EXECUTE;
      item.instr_word = iw;
      item.preload_index = 10'($urandom());
      item.preload_data = $urandom();
      send_item(item);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(cfg_index_type index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cfg_regs[index] = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(logic [31:0] pc, logic [31:0] sp, logic [31:0] a0,
                            logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
      csr_write(CFG_START, pc);
      csr_write(CFG_STACK, sp);
      csr_write(CFG_ARG0, a0);
      csr_write(CFG_ARG1, a1);
      csr_write(CFG_ARG2, a2);
      csr_write(CFG_ARG3, a3);
   endtask

   function automatic logic [31:0] dp_word(logic [3:0] op, bit imm, logic [3:0] rn,
                                           logic [3:0] rd, logic [7:0] op2);
      return {COND_AL, 2'b00, imm, op, 1'b0, rn, rd, 4'd0, op2};
   endfunction

   function automatic logic [31:0] sdt_word(bit load, bit byte_lane, bit up, bit reg_off,
                                            logic [3:0] rn, logic [3:0] rd,
                                            logic [7:0] off);
      return {COND_AL, 2'b01, reg_off, 1'b1, up, byte_lane, 1'b0, load, rn, rd, 4'd0,
              off};
   endfunction

   function automatic logic [31:0] branch_word(logic [3:0] cond, bit link,
                                               logic [23:0] off);
      return {cond, 3'b101, link, off};
   endfunction

   function automatic logic [31:0] bx_word(logic [3:0] rm);
      return BX_PATTERN | {28'd0, rm};
   endfunction

   function automatic logic [31:0] mul_word(logic [3:0] rd, logic [3:0] rs,
                                            logic [3:0] rm);
      return {COND_AL, 8'h00, rd, 4'd0, rs, 4'b1001, rm};
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] iw;
      logic [3:0] conds[4];
      int pick;
      conds = '{COND_EQ, COND_NE, COND_GE, COND_AL};
      iw = $urandom();
      pick = $urandom_range(99);
      if (pick < 8) begin
         iw = (iw & ~BX_MASK) | BX_PATTERN;
      end else if (pick < 16) begin
         iw = (iw & ~MUL_MASK) | MUL_PATTERN;
      end else if (pick < 50) begin
         iw[27:26] = 2'b00;
         case ($urandom_range(4))
            0: iw[24:21] = OP_ADD;
            1: iw[24:21] = OP_SUB;
            2: iw[24:21] = OP_MOV;
            3: iw[24:21] = OP_CMP;
            default: ;
         endcase
         if ((iw & MUL_MASK) == MUL_PATTERN || (iw & BX_MASK) == BX_PATTERN) iw[7] = 1'b0;
         if ($urandom_range(7) != 0 && iw[15:12] == REG_PC) iw[15:12] = 4'd4;
      end else if (pick < 72) begin
         iw[27:26] = 2'b01;
         if ($urandom_range(7) != 0 && iw[15:12] == REG_PC) iw[15:12] = 4'd5;
      end else if (pick < 90) begin
         iw[27:25] = 3'b101;
         if ($urandom_range(4) != 0) iw[31:28] = conds[$urandom_range(3)];
         if ($urandom_range(3) != 0) iw[23:0] = 24'($signed($urandom_range(64)) - 32);
      end
      return iw;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected transfer on rsp channel");
            failed = 1'b1;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload.next_pc !== want.next_pc) begin
               $error("next_pc: expected %h, got %h", want.next_pc, rsp_payload.next_pc);
               failed = 1'b1;
            end
            if (rsp_payload.result_value !== want.result_value) begin
               $error("result_value: expected %h, got %h", want.result_value,
                      rsp_payload.result_value);
               failed = 1'b1;
            end
            if (rsp_payload.halted !== want.halted) begin
               $error("halted: expected %b, got %b", want.halted, rsp_payload.halted);
               failed = 1'b1;
            end
            if (rsp_payload.instr_class !== want.instr_class) begin
               $error("instr_class: expected %0d, got %0d", want.instr_class,
                      rsp_payload.instr_class);
               failed = 1'b1;
            end
            if (rsp_payload.branch_taken !== want.branch_taken) begin
               $error("branch_taken: expected %b, got %b", want.branch_taken,
                      rsp_payload.branch_taken);
               failed = 1'b1;
            end
            if (rsp_payload.instr_count !== want.instr_count) begin
               $error("instr_count: expected %0d, got %0d", want.instr_count,
                      rsp_payload.instr_count);
               failed = 1'b1;
            end
            if (rsp_payload.compute_count !== want.compute_count) begin
               $error("compute_count: expected %0d, got %0d", want.compute_count,
                      rsp_payload.compute_count);
               failed = 1'b1;
            end
            if (rsp_payload.memory_count !== want.memory_count) begin
               $error("memory_count: expected %0d, got %0d", want.memory_count,
                      rsp_payload.memory_count);
               failed = 1'b1;
            end
            if (rsp_payload.branch_count !== want.branch_count) begin
               $error("branch_count: expected %0d, got %0d", want.branch_count,
                      rsp_payload.branch_count);
               failed = 1'b1;
            end
            if (rsp_payload.taken_count !== want.taken_count) begin
               $error("taken_count: expected %0d, got %0d", want.taken_count,
                      rsp_payload.taken_count);
               failed = 1'b1;
            end
            if (rsp_payload.not_taken_count !== want.not_taken_count) begin
               $error("not_taken_count: expected %0d, got %0d", want.not_taken_count,
                      rsp_payload.not_taken_count);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic test_reset_state();
      send_action(ACT_START);
      send_instr(dp_word(OP_MOV, 1'b1, 4'd0, 4'd0, 8'hFF));
      send_action(ACT_STATUS);
      wait_drain();
   endtask

   task automatic test_directed_ops();
      configure(32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0000_0000);
      send_preload(10'h3FF, 32'hFFFF_FFFF);
      send_preload(10'h000, 32'h0000_0000);
      send_action(ACT_START);
      send_instr(dp_word(OP_ADD, 1'b1, 4'd0, 4'd4, 8'hFF));
      send_instr(dp_word(OP_SUB, 1'b0, 4'd2, 4'd5, 8'h01));
      send_instr(dp_word(OP_CMP, 1'b0, 4'd0, 4'd0, 8'h01));
      send_instr(branch_word(COND_GE, 1'b0, 24'h000001));
      send_instr(dp_word(OP_CMP, 1'b0, 4'd1, 4'd0, 8'h02));
      send_instr(branch_word(COND_NE, 1'b0, 24'hFFFFFE));
      send_instr(dp_word(OP_CMP, 1'b0, 4'd3, 4'd0, 8'h03));
      send_instr(branch_word(COND_EQ, 1'b1, 24'h7FFFFF));
      send_instr(branch_word(4'h3, 1'b0, 24'h000010));
      send_instr(mul_word(4'd6, 4'd1, 4'd2));
      send_instr(sdt_word(1'b0, 1'b0, 1'b1, 1'b0, 4'd3, 4'd1, 8'h08));
      send_instr(sdt_word(1'b0, 1'b1, 1'b1, 1'b0, 4'd3, 4'd0, 8'h0B));
      send_instr(sdt_word(1'b1, 1'b0, 1'b0, 1'b1, 4'd3, 4'd7, 8'h05));
      send_instr(sdt_word(1'b1, 1'b1, 1'b1, 1'b0, 4'd3, 4'd8, 8'h0A));
      send_instr(dp_word(4'h0, 1'b1, 4'd0, 4'd9, 8'h12));
      send_instr(32'hEF00_0000);
      send_instr(dp_word(OP_MOV, 1'b1, 4'd0, REG_PC, 8'h40));
      send_instr(bx_word(4'd10));
      send_instr(dp_word(OP_ADD, 1'b1, 4'd0, 4'd0, 8'h01));
      send_action(ACT_STATUS);
      wait_drain();
   endtask

   task automatic test_random_program(int items, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      configure({30'($urandom_range(1, 32'h3FFF_FFFF)), 2'b00}, $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom());
      send_action(ACT_START);
      for (int n = 0; n < items; n++) begin
         if (cpu_regs[REG_PC] == 0 && $urandom_range(3) != 0)
            send_action(ACT_START);
         else if ($urandom_range(99) < 4)
            send_action(action_type'($urandom_range(1, 3)));
         else
            send_instr(random_instr());
      end
      wait_drain();
   endtask

   task automatic test_config_extremes();
      sender_idle_pct = 35;
      receiver_stall_pct = 35;
      configure(32'hFFFF_FFFC, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000);
      send_action(ACT_START);
      for (int n = 0; n < 20; n++) send_instr(random_instr());
      wait_drain();
      configure(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_action(ACT_START);
      send_instr(random_instr());
      wait_drain();
   endtask

   initial begin
      foreach (cpu_regs[i]) cpu_regs[i] = '0;
      foreach (mix_count[i]) mix_count[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      cpu_flags = '0;
      cfg_regs = '{32'd0, STACK_RESET, 32'd0, 32'd0, 32'd0, 32'd0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_ops();
      test_random_program(250, 0, 0);
      test_random_program(250, 88, 0);
      test_random_program(250, 0, 88);
      test_random_program(250, 35, 35);
      test_config_extremes();
      receiver_stall_pct = 0;
      wait_drain();
      repeat (10) @(posedge clock);
      if (!failed && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
